// ===== hdl/bhpq_pkg.sv =====
// bhpq_pkg: shared types, constants and the order compare for the binary heap queue
// used by bhpq_ctrl, bhpq_dp and binary_heap_priority_queue; no dependencies
`default_nettype none

package bhpq_pkg;

    // default heap capacity in elements
    localparam int CAPACITY_DEF = 63;

    // fixed payload widths
    localparam int VAL_W  = 32;
    localparam int FILL_W = 6;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // order modes
    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_MIN = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_BEGIN,
        S_UP_RD,
        S_UP_CMP,
        S_RM_TOP,
        S_RM_LAST,
        S_RM_INIT,
        S_DN_CHK,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_DN_DEC,
        S_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;     // capture request beat
        logic up_init;    // pos = count + 1, count++
        logic rd_parent;  // read parent of pos
        logic up_step;    // move parent down to pos, climb
        logic up_place;   // write new value at pos
        logic rd_top;     // read root
        logic rd_last;    // capture root, read last element
        logic dn_init;    // capture last, count--, start at root
        logic rd_child;   // read left child
        logic dn_left;    // capture left child, read right child
        logic dn_right;   // pick between children
        logic dn_step;    // move chosen child up, descend
        logic dn_place;   // write last element at parent
        logic finish;     // load result register
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_is_root;
        logic val_better;
        logic child_in;
        logic right_in;
        logic cand_better;
        logic rsp_free;
    } dp_stat_t;

    // true when a is strictly better than b in the given order
    function automatic logic better(input logic signed [VAL_W-1:0] a,
                                    input logic signed [VAL_W-1:0] b,
                                    input logic mode);
        logic res;
        if (mode == MODE_MIN)
            res = (a < b);
        else
            res = (a > b);
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bhpq_ctrl.sv =====
// bhpq_ctrl: state machine that sequences insert sift-up and remove sift-down
// depends on bhpq_pkg; drives bhpq_dp through ctrl_cmd_t, reads dp_stat_t
`default_nettype none

module bhpq_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    input  wire                  req_type,
    output logic                 req_stall,
    input  bhpq_pkg::dp_stat_t   stat,
    output bhpq_pkg::ctrl_cmd_t  cmd
);

    bhpq_pkg::state_t state_reg;
    bhpq_pkg::state_t state_next;
    logic             take;

    assign take      = req_valid && (state_reg == bhpq_pkg::S_IDLE);
    assign req_stall = (state_reg != bhpq_pkg::S_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bhpq_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bhpq_pkg::S_IDLE:
            begin
                if (take)
                begin
                    if (req_type == bhpq_pkg::REQ_INSERT)
                        state_next = stat.full ? bhpq_pkg::S_DONE : bhpq_pkg::S_INS_BEGIN;
                    else
                        state_next = stat.empty ? bhpq_pkg::S_DONE : bhpq_pkg::S_RM_TOP;
                end
            end
            bhpq_pkg::S_INS_BEGIN: state_next = bhpq_pkg::S_UP_RD;
            bhpq_pkg::S_UP_RD:
                state_next = stat.pos_is_root ? bhpq_pkg::S_DONE : bhpq_pkg::S_UP_CMP;
            bhpq_pkg::S_UP_CMP:
                state_next = stat.val_better ? bhpq_pkg::S_UP_RD : bhpq_pkg::S_DONE;
            bhpq_pkg::S_RM_TOP:    state_next = bhpq_pkg::S_RM_LAST;
            bhpq_pkg::S_RM_LAST:   state_next = bhpq_pkg::S_RM_INIT;
            bhpq_pkg::S_RM_INIT:   state_next = bhpq_pkg::S_DN_CHK;
            bhpq_pkg::S_DN_CHK:
                state_next = stat.child_in ? bhpq_pkg::S_DN_LEFT : bhpq_pkg::S_DONE;
            bhpq_pkg::S_DN_LEFT:
                state_next = stat.right_in ? bhpq_pkg::S_DN_RIGHT : bhpq_pkg::S_DN_DEC;
            bhpq_pkg::S_DN_RIGHT:  state_next = bhpq_pkg::S_DN_DEC;
            bhpq_pkg::S_DN_DEC:
                state_next = stat.cand_better ? bhpq_pkg::S_DN_CHK : bhpq_pkg::S_DONE;
            bhpq_pkg::S_DONE:
                if (stat.rsp_free)
                    state_next = bhpq_pkg::S_IDLE;
            default:               state_next = bhpq_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            bhpq_pkg::S_IDLE:      cmd.accept  = take;
            bhpq_pkg::S_INS_BEGIN: cmd.up_init = 1'b1;
            bhpq_pkg::S_UP_RD:
            begin
                cmd.up_place  = stat.pos_is_root;
                cmd.rd_parent = !stat.pos_is_root;
            end
            bhpq_pkg::S_UP_CMP:
            begin
                cmd.up_step  = stat.val_better;
                cmd.up_place = !stat.val_better;
            end
            bhpq_pkg::S_RM_TOP:    cmd.rd_top  = 1'b1;
            bhpq_pkg::S_RM_LAST:   cmd.rd_last = 1'b1;
            bhpq_pkg::S_RM_INIT:   cmd.dn_init = 1'b1;
            bhpq_pkg::S_DN_CHK:
            begin
                cmd.rd_child = stat.child_in;
                cmd.dn_place = !stat.child_in;
            end
            bhpq_pkg::S_DN_LEFT:   cmd.dn_left  = 1'b1;
            bhpq_pkg::S_DN_RIGHT:  cmd.dn_right = 1'b1;
            bhpq_pkg::S_DN_DEC:
            begin
                cmd.dn_step  = stat.cand_better;
                cmd.dn_place = !stat.cand_better;
            end
            bhpq_pkg::S_DONE:      cmd.finish = stat.rsp_free;
            default:               cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/bhpq_dp.sv =====
// bhpq_dp: heap store, element count, sift registers and result register
// depends on bhpq_pkg; commanded by bhpq_ctrl
`default_nettype none

module bhpq_dp #(
    parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_wen,
    input  wire                                   cfg_wdata,
    input  wire                                   req_type,
    input  wire signed [bhpq_pkg::VAL_W-1:0]      value,
    input  bhpq_pkg::ctrl_cmd_t                   cmd,
    output bhpq_pkg::dp_stat_t                    stat,
    output logic                                  rsp_valid,
    input  wire                                   rsp_stall,
    output logic signed [bhpq_pkg::VAL_W-1:0]     top_value,
    output logic [1:0]                            status,
    output logic [bhpq_pkg::FILL_W-1:0]           fill_count
);

    localparam int DEPTH = CAPACITY + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = bhpq_pkg::VAL_W;

    // heap store, slot 0 unused
    logic signed [VW-1:0] mem [DEPTH];
    logic signed [VW-1:0] rd_data_reg;

    logic                 mode_reg;
    logic [AW-1:0]        cnt_reg;
    logic [AW-1:0]        pos_reg;
    logic [AW-1:0]        parent_reg;
    logic [AW:0]          child_reg;
    logic signed [VW-1:0] val_reg;
    logic signed [VW-1:0] last_reg;
    logic signed [VW-1:0] left_reg;
    logic signed [VW-1:0] cand_reg;
    logic signed [VW-1:0] top_reg;
    bhpq_pkg::status_t    st_reg;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [VW-1:0] wr_data;
    logic [AW:0]          right_idx;
    logic                 take_right;

    assign right_idx  = child_reg + (AW+1)'(1);
    assign take_right = !bhpq_pkg::better(left_reg, rd_data_reg, mode_reg);

    // status toward the controller
    assign stat.full        = (cnt_reg >= AW'(CAPACITY));
    assign stat.empty       = (cnt_reg == '0);
    assign stat.pos_is_root = (pos_reg == AW'(1));
    assign stat.val_better  = bhpq_pkg::better(val_reg, rd_data_reg, mode_reg);
    assign stat.child_in    = (child_reg <= {1'b0, cnt_reg});
    assign stat.right_in    = (right_idx <= {1'b0, cnt_reg});
    assign stat.cand_better = bhpq_pkg::better(cand_reg, last_reg, mode_reg);
    assign stat.rsp_free    = !rsp_valid || !rsp_stall;

    // read address select
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = '0;
        if (cmd.rd_parent)
            rd_addr = pos_reg >> 1;
        else if (cmd.rd_top)
            rd_addr = AW'(1);
        else if (cmd.rd_last)
            rd_addr = cnt_reg;
        else if (cmd.rd_child)
            rd_addr = child_reg[AW-1:0];
        else if (cmd.dn_left && stat.right_in)
            rd_addr = right_idx[AW-1:0];
        else
            rd_en = 1'b0;
    end

    // write address and data select
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '0;
        if (cmd.up_step)
        begin
            wr_addr = pos_reg;
            wr_data = rd_data_reg;
        end
        else if (cmd.up_place)
        begin
            wr_addr = pos_reg;
            wr_data = val_reg;
        end
        else if (cmd.dn_step)
        begin
            wr_addr = parent_reg;
            wr_data = cand_reg;
        end
        else if (cmd.dn_place)
        begin
            wr_addr = parent_reg;
            wr_data = last_reg;
        end
        else
            wr_en = 1'b0;
    end

    // heap store ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // order mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= bhpq_pkg::MODE_MAX;
        else if (cfg_wen)
            mode_reg <= cfg_wdata;
    end

    // element count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.up_init)
            cnt_reg <= cnt_reg + AW'(1);
        else if (cmd.dn_init)
            cnt_reg <= cnt_reg - AW'(1);
    end

    // sift working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            val_reg <= value;
            top_reg <= '0;
            if (req_type == bhpq_pkg::REQ_INSERT)
                st_reg <= stat.full ? bhpq_pkg::ST_FULL : bhpq_pkg::ST_OK;
            else
                st_reg <= stat.empty ? bhpq_pkg::ST_EMPTY : bhpq_pkg::ST_OK;
        end
        if (cmd.up_init)
            pos_reg <= cnt_reg + AW'(1);
        if (cmd.up_step)
            pos_reg <= pos_reg >> 1;
        if (cmd.rd_last)
            top_reg <= rd_data_reg;
        if (cmd.dn_init)
        begin
            last_reg   <= rd_data_reg;
            parent_reg <= AW'(1);
            child_reg  <= (AW+1)'(2);
        end
        if (cmd.dn_left)
        begin
            left_reg <= rd_data_reg;
            cand_reg <= rd_data_reg;
        end
        if (cmd.dn_right && take_right)
        begin
            cand_reg  <= rd_data_reg;
            child_reg <= right_idx;
        end
        if (cmd.dn_step)
        begin
            parent_reg <= child_reg[AW-1:0];
            child_reg  <= child_reg << 1;
        end
    end

    // result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid <= 1'b0;
        else if (cmd.finish)
            rsp_valid <= 1'b1;
        else if (!rsp_stall)
            rsp_valid <= 1'b0;
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            top_value  <= top_reg;
            status     <= st_reg;
            fill_count <= bhpq_pkg::FILL_W'(cnt_reg);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/binary_heap_priority_queue.sv =====
// binary_heap_priority_queue: top level of the heap priority queue
// depends on bhpq_pkg, bhpq_ctrl and bhpq_dp
//
// Request channel: req_valid / req_stall with req_type (0 insert, 1 remove) and
// value. Result channel: rsp_valid / rsp_stall with top_value, status and
// fill_count; every request beat yields exactly one result beat, in order.
// order_mode is written through cfg_wen / cfg_wdata (0 max-heap, 1 min-heap);
// write it only while the queue is idle and empty.
// One request at a time, registered store reads. An insert reads and compares
// the parent once per level climbed and then writes the new value; a remove
// reads the root and the last element, then per level descended reads the
// left child, the right child if present, and compares. A refused request
// (full or empty) goes straight to the result; the result beat becomes valid
// in the same cycle that the next request can be taken.
// req_stall is low only while the controller is idle; a finished result waits
// in the output register, so a new request is taken while the receiver stalls,
// and the next result is held back until that register frees.
// Reset empties the queue and selects max-heap order; store contents are not
// cleared, since only slots up to the element count are ever read.
`default_nettype none

module binary_heap_priority_queue #(
    parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_wen,
    input  wire                                cfg_wdata,
    input  wire                                req_valid,
    output logic                               req_stall,
    input  wire                                req_type,
    input  wire signed [bhpq_pkg::VAL_W-1:0]   value,
    output logic                               rsp_valid,
    input  wire                                rsp_stall,
    output logic signed [bhpq_pkg::VAL_W-1:0]  top_value,
    output logic [1:0]                         status,
    output logic [bhpq_pkg::FILL_W-1:0]        fill_count
);

    bhpq_pkg::ctrl_cmd_t cmd;
    bhpq_pkg::dp_stat_t  stat;

    // sequencer
    bhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_type),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // heap store and registers
    bhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .req_type   (req_type),
        .value      (value),
        .cmd        (cmd),
        .stat       (stat),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .top_value  (top_value),
        .status     (status),
        .fill_count (fill_count)
    );

endmodule

`default_nettype wire

// ===== tb/binary_heap_priority_queue_tb.sv =====
// binary_heap_priority_queue_tb: self-checking bench for the heap priority queue
// uses bhpq_pkg and binary_heap_priority_queue; a scripted warm-up and random
// fill/drain phases in both orders are checked against typed-in results and an in-bench heap model
module binary_heap_priority_queue_tb;

    localparam int CAP          = bhpq_pkg::CAPACITY_DEF;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 150;
    localparam int SETTLE       = 30;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SCRIPT_LEN   = 24;

    // one result beat as the queue reports it
    typedef struct packed {
        logic [bhpq_pkg::VAL_W-1:0]  top;
        bhpq_pkg::status_t           st;
        logic [bhpq_pkg::FILL_W-1:0] fill;
    } heap_result_t;

    // warm-up row: request, and the result when it can be typed in
    typedef struct packed {
        logic                        rtype;
        logic [bhpq_pkg::VAL_W-1:0]  val;
        logic                        literal;
        logic [bhpq_pkg::VAL_W-1:0]  top;
        bhpq_pkg::status_t           st;
        logic [bhpq_pkg::FILL_W-1:0] fill;
    } script_row_t;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{bhpq_pkg::REQ_REMOVE, 32'h00000000, 1'b1, 32'h00000000, bhpq_pkg::ST_EMPTY, 6'd0},
        '{bhpq_pkg::REQ_INSERT, 32'h7FFFFFFF, 1'b1, 32'h00000000, bhpq_pkg::ST_OK,    6'd1},
        '{bhpq_pkg::REQ_INSERT, 32'h80000000, 1'b1, 32'h00000000, bhpq_pkg::ST_OK,    6'd2},
        '{bhpq_pkg::REQ_INSERT, 32'h00000000, 1'b1, 32'h00000000, bhpq_pkg::ST_OK,    6'd3},
        '{bhpq_pkg::REQ_INSERT, 32'hFFFFFFFF, 1'b1, 32'h00000000, bhpq_pkg::ST_OK,    6'd4},
        '{bhpq_pkg::REQ_REMOVE, 32'hFFFFFFFF, 1'b1, 32'h7FFFFFFF, bhpq_pkg::ST_OK,    6'd3},
        '{bhpq_pkg::REQ_REMOVE, 32'h00000000, 1'b1, 32'h00000000, bhpq_pkg::ST_OK,    6'd2},
        '{bhpq_pkg::REQ_REMOVE, 32'h12345678, 1'b1, 32'hFFFFFFFF, bhpq_pkg::ST_OK,    6'd1},
        '{bhpq_pkg::REQ_REMOVE, 32'h00000000, 1'b1, 32'h80000000, bhpq_pkg::ST_OK,    6'd0},
        '{bhpq_pkg::REQ_REMOVE, 32'hFFFFFFFF, 1'b1, 32'h00000000, bhpq_pkg::ST_EMPTY, 6'd0},
        // equal values force the right-child pick on the way down
        '{bhpq_pkg::REQ_INSERT, 32'h00000005, 1'b1, 32'h00000000, bhpq_pkg::ST_OK,    6'd1},
        '{bhpq_pkg::REQ_INSERT, 32'h00000005, 1'b1, 32'h00000000, bhpq_pkg::ST_OK,    6'd2},
        '{bhpq_pkg::REQ_INSERT, 32'h00000003, 1'b1, 32'h00000000, bhpq_pkg::ST_OK,    6'd3},
        '{bhpq_pkg::REQ_INSERT, 32'h00000005, 1'b1, 32'h00000000, bhpq_pkg::ST_OK,    6'd4},
        '{bhpq_pkg::REQ_INSERT, 32'h00000005, 1'b1, 32'h00000000, bhpq_pkg::ST_OK,    6'd5},
        '{bhpq_pkg::REQ_INSERT, 32'h00000004, 1'b1, 32'h00000000, bhpq_pkg::ST_OK,    6'd6},
        '{bhpq_pkg::REQ_REMOVE, 32'h00000000, 1'b0, 32'h00000000, bhpq_pkg::ST_OK,    6'd0},
        '{bhpq_pkg::REQ_REMOVE, 32'h00000000, 1'b0, 32'h00000000, bhpq_pkg::ST_OK,    6'd0},
        '{bhpq_pkg::REQ_REMOVE, 32'h00000000, 1'b0, 32'h00000000, bhpq_pkg::ST_OK,    6'd0},
        '{bhpq_pkg::REQ_REMOVE, 32'h00000000, 1'b0, 32'h00000000, bhpq_pkg::ST_OK,    6'd0},
        '{bhpq_pkg::REQ_REMOVE, 32'h00000000, 1'b0, 32'h00000000, bhpq_pkg::ST_OK,    6'd0},
        '{bhpq_pkg::REQ_REMOVE, 32'h00000000, 1'b0, 32'h00000000, bhpq_pkg::ST_OK,    6'd0},
        '{bhpq_pkg::REQ_INSERT, 32'hAAAAAAAA, 1'b1, 32'h00000000, bhpq_pkg::ST_OK,    6'd1},
        '{bhpq_pkg::REQ_REMOVE, 32'h55555555, 1'b1, 32'hAAAAAAAA, bhpq_pkg::ST_OK,    6'd0}
    };

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_wen;
    logic                               cfg_wdata;
    logic                               req_valid;
    logic                               req_stall;
    logic                               req_type;
    logic signed [bhpq_pkg::VAL_W-1:0]  value;
    logic                               rsp_valid;
    logic                               rsp_stall;
    logic signed [bhpq_pkg::VAL_W-1:0]  top_value;
    logic [1:0]                         status;
    logic [bhpq_pkg::FILL_W-1:0]        fill_count;

    // in-bench heap: contents, element count and current order
    logic signed [bhpq_pkg::VAL_W-1:0]  heap_mem [0:CAP];
    int unsigned                        heap_len;
    logic                               heap_order;

    heap_result_t                       pending_results [$];
    int                                 mismatches;
    int                                 quiet_cycles;
    int                                 gap_pct;
    int                                 stall_pct;

    binary_heap_priority_queue dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .value      (value),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .top_value  (top_value),
        .status     (status),
        .fill_count (fill_count)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // strict order compare under the current mode
    function automatic logic outranks(input logic signed [bhpq_pkg::VAL_W-1:0] a,
                                      input logic signed [bhpq_pkg::VAL_W-1:0] b);
        logic res;
        if (heap_order == bhpq_pkg::MODE_MIN)
            res = (a < b);
        else
            res = (a > b);
        return res;
    endfunction

    // apply one request to the heap model and return the result it yields
    function automatic heap_result_t serve_request(
        input logic rtype,
        input logic signed [bhpq_pkg::VAL_W-1:0] v);
        heap_result_t                      r;
        int unsigned                       pos;
        int unsigned                       parent;
        int unsigned                       child;
        int unsigned                       remaining;
        logic signed [bhpq_pkg::VAL_W-1:0] moved;
        r.top = '0;
        r.st  = bhpq_pkg::ST_OK;
        if (rtype == bhpq_pkg::REQ_INSERT)
        begin
            if (heap_len >= CAP)
                r.st = bhpq_pkg::ST_FULL;
            else
            begin
                // sift up while strictly better than the parent
                pos      = heap_len + 1;
                heap_len = pos;
                while (pos > 1 && outranks(v, heap_mem[pos / 2]))
                begin
                    heap_mem[pos] = heap_mem[pos / 2];
                    pos = pos / 2;
                end
                heap_mem[pos] = v;
            end
        end
        else if (heap_len == 0)
            r.st = bhpq_pkg::ST_EMPTY;
        else
        begin
            // take the root, sift the last element down from the top
            remaining = heap_len - 1;
            moved     = heap_mem[heap_len];
            r.top     = heap_mem[1];
            parent    = 1;
            child     = 2;
            while (child <= remaining)
            begin
                if (child + 1 <= remaining && !outranks(heap_mem[child], heap_mem[child + 1]))
                    child++;
                if (!outranks(heap_mem[child], moved))
                    break;
                heap_mem[parent] = heap_mem[child];
                parent = child;
                child  = child * 2;
            end
            heap_mem[parent] = moved;
            heap_len = remaining;
        end
        r.fill = heap_len[bhpq_pkg::FILL_W-1:0];
        return r;
    endfunction

    // random insert value: extremes, a narrow band for ties, or any word
    function automatic logic signed [bhpq_pkg::VAL_W-1:0] pick_value();
        logic signed [bhpq_pkg::VAL_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'sh7FFFFFFF;
            1:       v = 32'sh80000000;
            2, 3:    v = $signed($urandom_range(0, 8)) - 4;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // drive one request beat and hold it until taken; expects to start on an edge
    task automatic send_request(input logic rtype, input logic [bhpq_pkg::VAL_W-1:0] v,
                                input logic literal, input heap_result_t lit_res);
        heap_result_t predicted;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= rtype;
        value     <= v;
        do
            @(posedge clk);
        while (req_stall);
        predicted = serve_request(rtype, v);
        pending_results.push_back(literal ? lit_res : predicted);
    endtask

    // write the order register once the queue has gone quiet
    task automatic set_order(input logic mode);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        heap_order = mode;
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    // receiver stall bursts
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // result beat check and watchdog
    always @(posedge clk)
    begin
        heap_result_t want;
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_wen)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("binary_heap_priority_queue verification failed");
            $finish;
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (top_value !== want.top)
                begin
                    $error("top_value expected %0d actual %0d",
                           $signed(want.top), top_value);
                    mismatches++;
                end
                if (status !== want.st)
                begin
                    $error("status expected %0d actual %0d", want.st, status);
                    mismatches++;
                end
                if (fill_count !== want.fill)
                begin
                    $error("fill_count expected %0d actual %0d", want.fill, fill_count);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int           insert_pct;
        heap_result_t lit_res;
        logic         rtype;
        mismatches   = 0;
        quiet_cycles = 0;
        gap_pct      = 0;
        stall_pct    = 0;
        heap_len     = 0;
        heap_order   = bhpq_pkg::MODE_MAX;
        rst_n        = 1'b0;
        cfg_wen      = 1'b0;
        cfg_wdata    = 1'b0;
        req_valid    = 1'b0;
        req_type     = bhpq_pkg::REQ_INSERT;
        value        = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scripted warm-up in max order straight after reset
        gap_pct   = 25;
        stall_pct = 25;
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            lit_res.top  = SCRIPT[i].top;
            lit_res.st   = SCRIPT[i].st;
            lit_res.fill = SCRIPT[i].fill;
            send_request(SCRIPT[i].rtype, SCRIPT[i].val, SCRIPT[i].literal, lit_res);
        end

        // random phases: fill, drain, balanced; order alternates for the first four, then is random, with contents held
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 4)
                set_order(phase[0] ? bhpq_pkg::MODE_MAX : bhpq_pkg::MODE_MIN);
            else
                set_order(logic'($urandom_range(0, 1)));
            case (phase % 3)
                0:       insert_pct = 80;
                1:       insert_pct = 25;
                default: insert_pct = 50;
            endcase
            if (phase == PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = 10 * $urandom_range(0, 3);
                stall_pct = 10 * $urandom_range(0, 3);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                rtype = ($urandom_range(1, 100) <= insert_pct) ?
                        bhpq_pkg::REQ_INSERT : bhpq_pkg::REQ_REMOVE;
                if (rtype == bhpq_pkg::REQ_INSERT)
                    send_request(rtype, pick_value(), 1'b0, lit_res);
                else
                    send_request(rtype, $urandom, 1'b0, lit_res);
            end
        end
        req_valid <= 1'b0;

        // drain and settle
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("binary_heap_priority_queue verification clean");
        else
            $display("binary_heap_priority_queue verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bhpq_pkg.sv
hdl/bhpq_ctrl.sv
hdl/bhpq_dp.sv
hdl/binary_heap_priority_queue.sv
tb/binary_heap_priority_queue_tb.sv
